@@ design/assert_macros.svh @@
// Assertion helpers for checker files (included by sacc_checker).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sacc_pkg.sv @@
package sacc_pkg;

    localparam int unsigned TAG_W  = 32;
    localparam int unsigned RANK_W = 3;
    localparam int unsigned CNT_W  = 32;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_FETCH = 2'd2;

    localparam logic [1:0] REG_BLOCK = 2'd0;
    localparam logic [1:0] REG_SETS  = 2'd1;
    localparam logic [1:0] REG_WAYS  = 2'd2;
    localparam logic [1:0] REG_LRU   = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_OUT
    } state_t;

    // One way of a set, as held in the tag memory.
    typedef struct packed {
        logic              valid;
        logic              dirty;
        logic [RANK_W-1:0] rank;
        logic [TAG_W-1:0]  tag;
    } way_entry_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
        end
    endfunction

endpackage

@@ design/set_assoc_cache_tag_controller_top.sv @@
// Tag/valid/dirty controller for a write-back set-associative cache. Each beat
// on s_axis (command, address) yields one beat on m_axis with hit, writeback,
// fill, way and six saturating counters. The set's ways live in one row of a
// synchronous memory (MAX_SETS rows of MAX_WAYS entries); an access reads the
// row, compares and updates it in the next cycle (LOOKUP), and holds the result
// in OUT until it is taken; only then is a new access accepted. After reset
// a clearing pass walks all MAX_SETS rows, one per cycle, before the first
// access is taken; configuration writes are taken at any time, but change the
// geometry under an access in flight, so issue them only while none is pending.
module set_assoc_cache_tag_controller_top
    import sacc_pkg::*;
#(
    parameter int unsigned MAX_SETS = 1024,
    parameter int unsigned MAX_WAYS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // address[31:0]
    input  logic [1:0]   s_axis_tuser,   // command[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [199:0] m_axis_tdata,   // way_used[2:0], hits, misses, reads,
                                         // writes, bytes_from, bytes_to, pad
    output logic [2:0]   m_axis_tuser,   // hit, write_back, fill
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [3:0]   cfg_data
);
    localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int unsigned SMAX  = $clog2(MAX_SETS + 1) - 1;
    localparam int unsigned WMAX  = $clog2(MAX_WAYS + 1) - 1;
    localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    way_entry_t            mem [MAX_SETS][MAX_WAYS];
    logic [WAY_W-1:0]      fifo_mem [MAX_SETS];
    way_entry_t            row_q [MAX_WAYS];
    logic [WAY_W-1:0]      fptr_q;

    state_t                state_reg, state_next;
    logic [SET_W:0]        clr_reg, clr_next;
    logic [3:0]            bbl_reg;
    logic [3:0]            sl_reg;
    logic [1:0]            wl_reg;
    logic                  lru_reg;
    logic [1:0]            cmd_reg;
    logic [31:0]           addr_reg;
    logic [CNT_W-1:0]      cnt_reg [6];
    logic                  hit_reg, wb_reg;
    logic [2:0]            way_reg;

    // address geometry
    logic [3:0]            b_eff;
    logic [3:0]            s_eff;
    logic [1:0]            w_eff;
    logic [31:0]           blk, tag_c, bsize;
    logic [SET_W-1:0]      set_c;
    logic [WAY_W:0]        nways;

    always_comb
    begin
        b_eff = (bbl_reg < 4'd2) ? 4'd2 : ((bbl_reg > 4'd8) ? 4'd8 : bbl_reg);
        s_eff = (32'(sl_reg) > SMAX) ? 4'(SMAX) : sl_reg;
        w_eff = (32'(wl_reg) > WMAX) ? 2'(WMAX) : wl_reg;
        nways = (WAY_W+1)'(1) << w_eff;
        blk   = addr_reg >> b_eff;
        set_c = SET_W'(blk & ((32'd1 << s_eff) - 32'd1));
        tag_c = blk >> s_eff;
        bsize = 32'd1 << b_eff;
    end

    // set index of the incoming beat
    logic [SET_W-1:0] in_set;
    always_comb
    begin
        in_set = SET_W'((s_axis_tdata >> b_eff)
                 & ((32'd1 << s_eff) - 32'd1));
    end

    // lookup and update of the row read last cycle
    logic                  hit_c, found_c, wb_c;
    logic [WAY_W-1:0]      way_c;
    logic [RANK_W:0]       old_rank;
    logic [RANK_W-1:0]     best;
    way_entry_t            new_row [MAX_WAYS];
    logic [WAY_W-1:0]      fptr_new;

    always_comb
    begin
        hit_c    = 1'b0;
        found_c  = 1'b0;
        way_c    = '0;
        best     = '0;
        wb_c     = 1'b0;
        fptr_new = fptr_q;
        for (int j = MAX_WAYS - 1; j >= 0; j--)
        begin
            if ((WAY_W+1)'(j) < nways && row_q[j].valid && row_q[j].tag == tag_c)
            begin
                hit_c = 1'b1;
                way_c = WAY_W'(j);
            end
        end
        old_rank = {1'b0, row_q[way_c].rank};
        if (!hit_c)
        begin
            for (int j = MAX_WAYS - 1; j >= 0; j--)
            begin
                if ((WAY_W+1)'(j) < nways && !row_q[j].valid)
                begin
                    found_c = 1'b1;
                    way_c   = WAY_W'(j);
                end
            end
            if (!found_c)
            begin
                if (lru_reg)
                begin
                    way_c = '0;
                    for (int j = 0; j < MAX_WAYS; j++)
                    begin
                        if ((WAY_W+1)'(j) < nways && row_q[j].rank > best)
                        begin
                            best  = row_q[j].rank;
                            way_c = WAY_W'(j);
                        end
                    end
                end
                else
                begin
                    way_c    = fptr_q & WAY_W'(nways - 1'b1);
                    fptr_new = WAY_W'((way_c + 1'b1) & WAY_W'(nways - 1'b1));
                end
                old_rank = {1'b0, row_q[way_c].rank};
                wb_c     = row_q[way_c].valid && row_q[way_c].dirty;
            end
            else
            begin
                old_rank = (RANK_W+1)'(8);
            end
        end
        for (int j = 0; j < MAX_WAYS; j++)
        begin
            new_row[j] = row_q[j];
            if ((WAY_W+1)'(j) < nways && WAY_W'(j) != way_c && row_q[j].valid
                && {1'b0, row_q[j].rank} < old_rank && row_q[j].rank != 3'd7)
                new_row[j].rank = row_q[j].rank + 1'b1;
        end
        new_row[way_c].rank = '0;
        if (!hit_c)
        begin
            new_row[way_c].tag   = tag_c;
            new_row[way_c].valid = 1'b1;
        end
        if (cmd_reg == CMD_WRITE)
            new_row[way_c].dirty = 1'b1;
        else if (!hit_c)
            new_row[way_c].dirty = 1'b0;
    end

    // memory: one row-wide write port and one row-wide read port
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            for (int j = 0; j < MAX_WAYS; j++)
                mem[clr_reg[SET_W-1:0]][j] <= '0;
            fifo_mem[clr_reg[SET_W-1:0]] <= '0;
        end
        else if (state_reg == ST_LOOKUP)
        begin
            for (int j = 0; j < MAX_WAYS; j++)
                mem[set_c][j] <= new_row[j];
            fifo_mem[set_c] <= fptr_new;
        end
        for (int j = 0; j < MAX_WAYS; j++)
            row_q[j] <= mem[in_set][j];
        fptr_q <= fifo_mem[in_set];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (SET_W+1)'(MAX_SETS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:   if (s_axis_tvalid) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_OUT;
            ST_OUT:    if (m_axis_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        m_axis_tvalid = (state_reg == ST_OUT);
        cfg_ready     = 1'b1;
    end

    assign m_axis_tuser = {~hit_reg, wb_reg, hit_reg};
    assign m_axis_tdata = {5'd0, cnt_reg[5], cnt_reg[4], cnt_reg[3], cnt_reg[2],
                           cnt_reg[1], cnt_reg[0], way_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            bbl_reg   <= 4'd4;
            sl_reg    <= 4'd6;
            wl_reg    <= 2'd0;
            lru_reg   <= 1'b0;
            for (int i = 0; i < 6; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_BLOCK: bbl_reg <= cfg_data;
                    REG_SETS:  sl_reg  <= cfg_data;
                    REG_WAYS:  wl_reg  <= cfg_data[1:0];
                    REG_LRU:   lru_reg <= cfg_data[0];
                    default:   ;
                endcase
            end
            if (state_reg == ST_LOOKUP)
            begin
                if (hit_c)
                    cnt_reg[0] <= sat_add(cnt_reg[0], 32'd1);
                else
                begin
                    cnt_reg[1] <= sat_add(cnt_reg[1], 32'd1);
                    cnt_reg[4] <= sat_add(cnt_reg[4], bsize);
                end
                if (wb_c)
                    cnt_reg[5] <= sat_add(cnt_reg[5], bsize);
                if (cmd_reg == CMD_WRITE)
                    cnt_reg[3] <= sat_add(cnt_reg[3], 32'd1);
                else if (cmd_reg == CMD_READ)
                    cnt_reg[2] <= sat_add(cnt_reg[2], 32'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg  <= s_axis_tuser;
            addr_reg <= s_axis_tdata;
        end
        if (state_reg == ST_LOOKUP)
        begin
            hit_reg <= hit_c;
            wb_reg  <= wb_c;
            way_reg <= 3'(way_c);
        end
    end

endmodule

@@ design/sacc_checker.sv @@
`include "assert_macros.svh"
module sacc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [2:0]   m_axis_tuser,
    input logic [199:0] m_axis_tdata
);
    // a beat is either a hit or a fill
    `CHK_IMPL(a_hit_xor_fill, clk, rst_n, m_axis_tvalid, m_axis_tuser[0] != m_axis_tuser[2], "hit/fill")
    // writeback only on a miss
    `CHK_IMPL(a_wb_miss, clk, rst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[2], "wb on hit")
    // no new input while a result waits
    `CHK_IMPL(a_one_inflight, clk, rst_n, m_axis_tvalid, !s_axis_tready, "overlap")
    // stalled result holds
    `CHK_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "hold")
endmodule

bind set_assoc_cache_tag_controller_top sacc_checker u_chk (.*);

@@ test/cache_tag_checker.sv @@
module cache_tag_checker
    import sacc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [199:0] m_axis_tdata,
    input  logic [2:0]   m_axis_tuser,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [3:0]   cfg_data,
    output int           fail_count,
    output int           pending,
    output int           lookups_seen
);

    localparam int NSETS = 1024;
    localparam int NWAYS = 8;

    typedef struct packed {
        logic        hit;
        logic        write_back;
        logic        fill;
        logic [2:0]  way_used;
        logic [31:0] hits_total;
        logic [31:0] misses_total;
        logic [31:0] reads_total;
        logic [31:0] writes_total;
        logic [31:0] bytes_from_memory;
        logic [31:0] bytes_to_memory;
    } lookup_result_t;

    logic [31:0] tag_mem   [NSETS*NWAYS];
    logic        valid_mem [NSETS*NWAYS];
    logic        dirty_mem [NSETS*NWAYS];
    logic [2:0]  rank_mem  [NSETS*NWAYS];
    logic [2:0]  fifo_ptr  [NSETS];
    logic [31:0] counters  [6];
    logic [3:0]  blk_log2, set_log2;
    logic [1:0]  way_log2;
    logic        use_lru;

    lookup_result_t expected_q[$];

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void age_ways(input int base, input int nw, input int way,
                                     input int old_rank);
        for (int j = 0; j < nw; j++)
            if (j != way && valid_mem[base+j] && rank_mem[base+j] < old_rank
                    && rank_mem[base+j] < 7)
                rank_mem[base+j] = rank_mem[base+j] + 3'd1;
        rank_mem[base+way] = 3'd0;
    endfunction

    function automatic lookup_result_t predict_lookup(input logic [1:0] cmd,
                                                      input logic [31:0] addr);
        lookup_result_t r;
        int b, s, nw, base, way, old_rank, best;
        logic [31:0] blk, tag, set;
        logic hit, wb, found;
        b = blk_log2 < 2 ? 2 : (blk_log2 > 8 ? 8 : blk_log2);
        s = set_log2 > 10 ? 10 : set_log2;
        nw = 1 << way_log2;
        blk = addr >> b;
        set = blk & ((32'd1 << s) - 32'd1);
        tag = blk >> s;
        base = set * NWAYS;
        way = 0;
        hit = 1'b0;
        wb = 1'b0;
        for (int j = 0; j < nw; j++)
            if (!hit && valid_mem[base+j] && tag_mem[base+j] == tag)
            begin
                hit = 1'b1;
                way = j;
            end
        if (hit)
        begin
            age_ways(base, nw, way, rank_mem[base+way]);
            counters[0] = add_sat(counters[0], 32'd1);
        end
        else
        begin
            found = 1'b0;
            old_rank = 8;
            counters[1] = add_sat(counters[1], 32'd1);
            for (int j = 0; j < nw; j++)
                if (!found && !valid_mem[base+j])
                begin
                    found = 1'b1;
                    way = j;
                end
            if (!found)
            begin
                if (use_lru)
                begin
                    best = 0;
                    for (int j = 0; j < nw; j++)
                        if (rank_mem[base+j] > best)
                        begin
                            best = rank_mem[base+j];
                            way = j;
                        end
                end
                else
                begin
                    way = fifo_ptr[set] & (nw - 1);
                    fifo_ptr[set] = 3'((way + 1) & (nw - 1));
                end
                old_rank = rank_mem[base+way];
                wb = valid_mem[base+way] && dirty_mem[base+way];
            end
            tag_mem[base+way] = tag;
            valid_mem[base+way] = 1'b1;
            counters[4] = add_sat(counters[4], 32'd1 << b);
            if (wb)
                counters[5] = add_sat(counters[5], 32'd1 << b);
            age_ways(base, nw, way, old_rank);
        end
        if (cmd == CMD_WRITE)
        begin
            dirty_mem[base+way] = 1'b1;
            counters[3] = add_sat(counters[3], 32'd1);
        end
        else
        begin
            if (!hit)
                dirty_mem[base+way] = 1'b0;
            if (cmd == CMD_READ)
                counters[2] = add_sat(counters[2], 32'd1);
        end
        r.hit = hit;
        r.write_back = wb;
        r.fill = !hit;
        r.way_used = way[2:0];
        r.hits_total = counters[0];
        r.misses_total = counters[1];
        r.reads_total = counters[2];
        r.writes_total = counters[3];
        r.bytes_from_memory = counters[4];
        r.bytes_to_memory = counters[5];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH beat %0d %s: got %0h want %0h", lookups_seen, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        for (int i = 0; i < NSETS*NWAYS; i++)
        begin
            tag_mem[i] = 32'd0;
            valid_mem[i] = 1'b0;
            dirty_mem[i] = 1'b0;
            rank_mem[i] = 3'd0;
        end
        for (int i = 0; i < NSETS; i++)
            fifo_ptr[i] = 3'd0;
        for (int i = 0; i < 6; i++)
            counters[i] = 32'd0;
        blk_log2 = 4'd4;
        set_log2 = 4'd6;
        way_log2 = 2'd0;
        use_lru = 1'b0;
        fail_count = 0;
        pending = 0;
        lookups_seen = 0;
    end

    always @(posedge clk)
    begin
        lookup_result_t want;
        lookup_result_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BLOCK: blk_log2 = cfg_data;
                    REG_SETS:  set_log2 = cfg_data;
                    REG_WAYS:  way_log2 = cfg_data[1:0];
                    REG_LRU:   use_lru = cfg_data[0];
                    default:   ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(predict_lookup(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                lookups_seen++;
                got.hit = m_axis_tuser[0];
                got.write_back = m_axis_tuser[1];
                got.fill = m_axis_tuser[2];
                got.way_used = m_axis_tdata[2:0];
                got.hits_total = m_axis_tdata[34:3];
                got.misses_total = m_axis_tdata[66:35];
                got.reads_total = m_axis_tdata[98:67];
                got.writes_total = m_axis_tdata[130:99];
                got.bytes_from_memory = m_axis_tdata[162:131];
                got.bytes_to_memory = m_axis_tdata[194:163];
                if (expected_q.size() == 0)
                begin
                    report_mismatch("result with nothing expected", 32'd1, 32'd0);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.hit != want.hit)
                        report_mismatch("hit", 32'(got.hit), 32'(want.hit));
                    if (got.write_back != want.write_back)
                        report_mismatch("write_back", 32'(got.write_back),
                                        32'(want.write_back));
                    if (got.fill != want.fill)
                        report_mismatch("fill", 32'(got.fill), 32'(want.fill));
                    if (got.way_used != want.way_used)
                        report_mismatch("way_used", 32'(got.way_used), 32'(want.way_used));
                    if (got.hits_total != want.hits_total)
                        report_mismatch("hits_total", got.hits_total, want.hits_total);
                    if (got.misses_total != want.misses_total)
                        report_mismatch("misses_total", got.misses_total, want.misses_total);
                    if (got.reads_total != want.reads_total)
                        report_mismatch("reads_total", got.reads_total, want.reads_total);
                    if (got.writes_total != want.writes_total)
                        report_mismatch("writes_total", got.writes_total, want.writes_total);
                    if (got.bytes_from_memory != want.bytes_from_memory)
                        report_mismatch("bytes_from_memory", got.bytes_from_memory,
                                        want.bytes_from_memory);
                    if (got.bytes_to_memory != want.bytes_to_memory)
                        report_mismatch("bytes_to_memory", got.bytes_to_memory,
                                        want.bytes_to_memory);
                end
            end
            pending = expected_q.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
module tb_top;
    import sacc_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [199:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [3:0]   cfg_data;
    int           fail_count;
    int           pending;
    int           lookups_seen;
    int           stall_pct;
    int           idle_cycles;
    int           addr_pool_mask;

    localparam int WATCHDOG_LIMIT = 20000;

    set_assoc_cache_tag_controller_top uut (.*);

    cache_tag_checker checker_i (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_READ;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_BLOCK;
        cfg_data = '0;
        stall_pct = 14;
        addr_pool_mask = 32'h0000_3FFF;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Random backpressure on the result side.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // Count cycles with no beat on any channel.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired, %0d results outstanding", pending);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_access(input logic [1:0] cmd, input logic [31:0] addr);
        while ($urandom_range(99) < stall_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= addr;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        // Mostly a small working set so sets fill, hit and evict; some wide addresses.
        a = $urandom();
        if ($urandom_range(9) < 8)
            a = a & addr_pool_mask;
        return a;
    endfunction

    task automatic run_phase(input int count, input logic [3:0] blk, input logic [3:0] sets,
                             input logic [1:0] ways, input logic lru, input int mask);
        write_reg(REG_BLOCK, blk);
        write_reg(REG_SETS, sets);
        write_reg(REG_WAYS, ways);
        write_reg(REG_LRU, {3'd0, lru});
        addr_pool_mask = mask;
        for (int i = 0; i < count; i++)
            send_access(2'($urandom_range(3)), pick_addr());
        drain();
    endtask

    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        // Directed: reset geometry, extremes of address, all commands, command three.
        send_access(CMD_READ, 32'h0000_0000);
        send_access(CMD_READ, 32'h0000_0000);
        send_access(CMD_WRITE, 32'h0000_0004);
        send_access(CMD_FETCH, 32'hFFFF_FFFF);
        send_access(2'd3, 32'hFFFF_FFF0);
        send_access(CMD_WRITE, 32'h0000_0400);
        send_access(CMD_READ, 32'h0000_0000);
        send_access(CMD_WRITE, 32'hAAAA_5555);
        send_access(CMD_READ, 32'h5555_AAAA);
        drain();
        // Out-of-range block size, too many sets, 8 ways LRU: fill then evict.
        write_reg(REG_BLOCK, 4'd15);
        write_reg(REG_SETS, 4'd15);
        write_reg(REG_WAYS, 2'd3);
        write_reg(REG_LRU, 4'd1);
        for (int i = 0; i < 10; i++)
            send_access(CMD_WRITE, 32'(i) << 18);
        send_access(CMD_READ, 32'h0000_0000);
        drain();
        write_reg(REG_BLOCK, 4'd0);
        write_reg(REG_SETS, 4'd0);
        run_phase(250, 4'd2, 4'd0, 2'd2, 1'b0, 32'h0000_00FF);
        run_phase(250, 4'd8, 4'd10, 2'd3, 1'b1, 32'h0003_FFFF);
        run_phase(250, 4'd4, 4'd2, 2'd1, 1'b0, 32'h0000_0FFF);
        run_phase(250, 4'd5, 4'd3, 2'd3, 1'b1, 32'h0000_3FFF);
        // Stretch with no idling on either side.
        stall_pct = 0;
        run_phase(300, 4'd3, 4'd1, 2'd2, 1'b1, 32'h0000_07FF);
        stall_pct = 14;
        run_phase(350, 4'd0, 4'd12, 2'd0, 1'b0, 32'h0000_FFFF);
        $display("covered %0d lookups over several geometries (1 to 8 ways, 1 to 1024 sets,",
                 lookups_seen);
        $display("4 to 256 byte blocks) with FIFO and LRU victims and random stalls");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/sacc_pkg.sv
design/set_assoc_cache_tag_controller_top.sv
design/sacc_checker.sv
test/cache_tag_checker.sv
test/tb_top.sv
